// ===== rtl/chfrp_pkg.sv =====
// Shared constants, types and the FD length table of the host frame receive parser.
`timescale 1ns / 1ps
package chfrp_pkg;

  localparam int HEADER_BYTES          = 12;
  localparam int FD_PAYLOAD_BYTES      = 64;
  localparam int CLASSIC_PAYLOAD_BYTES = 8;
  localparam int MAX_CHANNELS          = 8;
  localparam int STAMP_BYTES           = 4;
  localparam int BANKS                 = 2;
  localparam int WORDS_PER_BANK        = FD_PAYLOAD_BYTES / 8;

  localparam int POS_W     = 7;
  localparam int LEN_W     = 7;
  localparam int WORD_W    = $clog2(WORDS_PER_BANK);
  localparam int MEM_AW    = $clog2(BANKS * WORDS_PER_BANK);
  localparam int CFG_IDX_W = 4;

  localparam logic [POS_W-1:0] POS_LIMIT    = 7'd127;
  localparam logic [31:0]      RX_ECHO_MARK = 32'hFFFF_FFFF;

  localparam int FLAG_FD_BIT  = 1;
  localparam int FLAG_BRS_BIT = 2;
  localparam int FLAG_ESI_BIT = 3;
  localparam int RTR_BIT      = 30;

  localparam logic [POS_W-1:0] POS_ECHO_END = 7'd4;
  localparam logic [POS_W-1:0] POS_ID_END   = 7'd8;
  localparam logic [POS_W-1:0] POS_DLC      = 7'd8;
  localparam logic [POS_W-1:0] POS_CHAN     = 7'd9;
  localparam logic [POS_W-1:0] POS_FLAGS    = 7'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMESTAMP_ENABLE = 4'd1;

  typedef struct packed {
    logic [2:0]       chan;
    logic [31:0]      frame_id;
    logic [LEN_W-1:0] payload_length;
    logic             is_fd;
    logic             bit_rate_switch;
    logic             error_passive;
    logic [31:0]      timestamp_us;
  } frame_desc_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [2:0]        lane;
    logic [7:0]        data;
  } mem_wr_t;

  function automatic logic [LEN_W-1:0] fd_length(input logic [3:0] code);
    logic [LEN_W-1:0] len;
    case (code)
      4'd9:    len = 7'd12;
      4'd10:   len = 7'd16;
      4'd11:   len = 7'd20;
      4'd12:   len = 7'd24;
      4'd13:   len = 7'd32;
      4'd14:   len = 7'd48;
      4'd15:   len = 7'd64;
      default: len = {3'b000, code};
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/chfrp_channels_if.sv =====
// Handshake channel interfaces: packet bytes in, frame words out, register writes.
`timescale 1ns / 1ps
interface chfrp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;
  modport source (output valid, data_byte, end_of_packet, input ready);
  modport sink   (input valid, data_byte, end_of_packet, output ready);
endinterface

interface chfrp_result_if;
  logic                       valid;
  logic                       ready;
  logic [2:0]                 chan;
  logic [31:0]                frame_id;
  logic [chfrp_pkg::LEN_W-1:0] payload_length;
  logic                       is_fd;
  logic                       bit_rate_switch;
  logic                       error_passive;
  logic [31:0]                timestamp_us;
  logic [2:0]                 word_index;
  logic [63:0]                payload_word;
  logic                       last_word;
  modport source (output valid, chan, frame_id, payload_length, is_fd, bit_rate_switch,
                  error_passive, timestamp_us, word_index, payload_word, last_word,
                  input ready);
  modport sink   (input valid, chan, frame_id, payload_length, is_fd, bit_rate_switch,
                  error_passive, timestamp_us, word_index, payload_word, last_word,
                  output ready);
endinterface

interface chfrp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [chfrp_pkg::CFG_IDX_W-1:0] reg_index;
  logic [7:0]                     wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== rtl/chfrp_front.sv =====
// Front end: config registers, byte parser, payload writes and frame checks at packet end.
`timescale 1ns / 1ps
module chfrp_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic [7:0]                       in_data_byte,
  input  logic                             in_end_of_packet,
  output logic                             in_ready,
  input  logic                             cfg_valid,
  input  logic [chfrp_pkg::CFG_IDX_W-1:0]  cfg_reg_index,
  input  logic [7:0]                       cfg_wdata,
  input  logic                             q_full,
  output logic                             push,
  output chfrp_pkg::frame_desc_t           push_desc,
  output chfrp_pkg::mem_wr_t               mem_wr
);

  logic [3:0]                   chan_count_r;
  logic [7:0]                   ts_enable_r;
  logic [chfrp_pkg::POS_W-1:0]  pos_r;
  logic [31:0]                  echo_r;
  logic [31:0]                  id_r;
  logic [7:0]                   dlc_r;
  logic [7:0]                   chan_byte_r;
  logic [7:0]                   flag_r;
  logic [31:0]                  stamp_r;
  logic [31:0]                  stamp_nxt;
  logic                         bank_r;

  logic                         accept;
  logic                         take;
  logic [chfrp_pkg::POS_W-1:0]  count;
  logic [chfrp_pkg::POS_W-1:0]  area;
  logic [chfrp_pkg::POS_W-1:0]  ts_start;
  logic [chfrp_pkg::POS_W-1:0]  ts_off;
  logic [chfrp_pkg::POS_W-1:0]  pay_idx;
  logic                         in_payload;
  logic                         in_stamp;
  logic                         fd;
  logic                         ts_on;
  logic [chfrp_pkg::LEN_W-1:0]  len;
  logic [7:0]                   need;
  logic                         frame_ok;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign take     = pos_r < chfrp_pkg::POS_LIMIT;
  assign count    = take ? pos_r + 7'd1 : chfrp_pkg::POS_LIMIT;

  assign fd       = flag_r[chfrp_pkg::FLAG_FD_BIT];
  assign area     = fd ? 7'(chfrp_pkg::FD_PAYLOAD_BYTES) : 7'(chfrp_pkg::CLASSIC_PAYLOAD_BYTES);
  assign ts_start = 7'(chfrp_pkg::HEADER_BYTES) + area;
  assign ts_off   = pos_r - ts_start;
  assign in_stamp = take && (pos_r >= ts_start) &&
                    (pos_r < ts_start + 7'(chfrp_pkg::STAMP_BYTES));
  assign pay_idx  = pos_r - 7'(chfrp_pkg::HEADER_BYTES);
  assign in_payload = (pos_r >= 7'(chfrp_pkg::HEADER_BYTES)) &&
                      (pos_r < 7'(chfrp_pkg::HEADER_BYTES + chfrp_pkg::FD_PAYLOAD_BYTES));

  always_comb begin
    stamp_nxt = stamp_r;
    if (accept && in_stamp) begin
      stamp_nxt[ts_off[1:0]*8 +: 8] = in_data_byte;
    end
  end

  always_comb begin
    if (fd) begin
      len = chfrp_pkg::fd_length((dlc_r > 8'd15) ? 4'd15 : dlc_r[3:0]);
    end else if (id_r[chfrp_pkg::RTR_BIT]) begin
      len = '0;
    end else begin
      len = (dlc_r > 8'(chfrp_pkg::CLASSIC_PAYLOAD_BYTES)) ?
            7'(chfrp_pkg::CLASSIC_PAYLOAD_BYTES) : dlc_r[6:0];
    end
  end

  assign ts_on = ts_enable_r[chan_byte_r[2:0]];
  assign need  = ts_on ? 8'(ts_start) + 8'(chfrp_pkg::STAMP_BYTES)
                       : 8'(chfrp_pkg::HEADER_BYTES) + {1'b0, len};

  assign frame_ok = (count >= 7'(chfrp_pkg::HEADER_BYTES)) &&
                    ({4'd0, chan_count_r} > chan_byte_r) &&
                    (chan_byte_r < 8'(chfrp_pkg::MAX_CHANNELS)) &&
                    (echo_r == chfrp_pkg::RX_ECHO_MARK) &&
                    ({1'b0, count} >= need);

  assign push = accept && in_end_of_packet && frame_ok;

  always_comb begin
    push_desc.chan            = chan_byte_r[2:0];
    push_desc.frame_id        = id_r;
    push_desc.payload_length  = len;
    push_desc.is_fd           = fd;
    push_desc.bit_rate_switch = flag_r[chfrp_pkg::FLAG_BRS_BIT];
    push_desc.error_passive   = flag_r[chfrp_pkg::FLAG_ESI_BIT];
    push_desc.timestamp_us    = ts_on ? stamp_nxt : '0;
  end

  always_comb begin
    mem_wr.en   = accept && in_payload;
    mem_wr.addr = {bank_r, pay_idx[5:3]};
    mem_wr.lane = pay_idx[2:0];
    mem_wr.data = in_data_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_count_r <= 4'd1;
      ts_enable_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_index)
        chfrp_pkg::CFG_CHANNEL_COUNT:    chan_count_r <= cfg_wdata[3:0];
        chfrp_pkg::CFG_TIMESTAMP_ENABLE: ts_enable_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      echo_r      <= '0;
      id_r        <= '0;
      dlc_r       <= '0;
      chan_byte_r <= '0;
      flag_r      <= '0;
      stamp_r     <= '0;
      bank_r      <= 1'b0;
    end else begin
      stamp_r <= stamp_nxt;
      if (push) begin
        bank_r <= !bank_r;
      end
      if (accept) begin
        pos_r <= in_end_of_packet ? '0 : count;
        if (pos_r < chfrp_pkg::POS_ECHO_END) begin
          echo_r[pos_r[1:0]*8 +: 8] <= in_data_byte;
        end else if (pos_r < chfrp_pkg::POS_ID_END) begin
          id_r[pos_r[1:0]*8 +: 8] <= in_data_byte;
        end else if (pos_r == chfrp_pkg::POS_DLC) begin
          dlc_r <= in_data_byte;
        end else if (pos_r == chfrp_pkg::POS_CHAN) begin
          chan_byte_r <= in_data_byte;
        end else if (pos_r == chfrp_pkg::POS_FLAGS) begin
          flag_r <= in_data_byte;
        end
      end
    end
  end

endmodule

// ===== rtl/chfrp_queue.sv =====
// Two-entry frame descriptor queue; the read pointer names the payload bank of the head frame.
`timescale 1ns / 1ps
module chfrp_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  chfrp_pkg::frame_desc_t push_desc,
  input  logic                   pop,
  output logic                   full,
  output logic                   head_valid,
  output chfrp_pkg::frame_desc_t head_desc,
  output logic                   head_bank
);

  chfrp_pkg::frame_desc_t entry_r [chfrp_pkg::BANKS];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full       = count_r == 2'd2;
  assign head_valid = count_r != 2'd0;
  assign head_desc  = entry_r[rd_ptr_r];
  assign head_bank  = rd_ptr_r;

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/chfrp_back.sv =====
// Back end: two-bank payload memory and the word sequencer that drains one frame at a time.
`timescale 1ns / 1ps
module chfrp_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  chfrp_pkg::mem_wr_t                mem_wr,
  input  logic                              head_valid,
  input  chfrp_pkg::frame_desc_t            head_desc,
  input  logic                              head_bank,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output chfrp_pkg::frame_desc_t            out_desc,
  output logic [chfrp_pkg::WORD_W-1:0]      out_word_index,
  output logic [63:0]                       out_payload_word,
  output logic                              out_last_word
);

  logic [63:0] mem [chfrp_pkg::BANKS * chfrp_pkg::WORDS_PER_BANK];

  logic [chfrp_pkg::WORD_W-1:0] w_r;
  logic [chfrp_pkg::WORD_W-1:0] words_m1;
  logic [chfrp_pkg::LEN_W-1:0]  len_m1;
  logic                         last;
  logic                         issue;
  logic [7:0]                   mask;

  logic                         rd_valid_r;
  logic [63:0]                  rd_data_r;
  chfrp_pkg::frame_desc_t       rd_desc_r;
  logic [chfrp_pkg::WORD_W-1:0] rd_word_r;
  logic                         rd_last_r;
  logic [7:0]                   rd_mask_r;
  logic [63:0]                  masked;

  logic                         out_valid_r;
  chfrp_pkg::frame_desc_t       out_desc_r;
  logic [chfrp_pkg::WORD_W-1:0] out_word_r;
  logic [63:0]                  out_data_r;
  logic                         out_last_r;

  assign len_m1   = head_desc.payload_length - 7'd1;
  assign words_m1 = (head_desc.payload_length == '0) ? '0 : len_m1[5:3];
  assign last     = w_r == words_m1;
  assign issue    = head_valid && !rd_valid_r && (!out_valid_r || out_ready);
  assign pop      = issue && last;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      mask[k] = {1'b0, w_r, 3'(k)} < head_desc.payload_length;
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      masked[k*8 +: 8] = rd_mask_r[k] ? rd_data_r[k*8 +: 8] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      mem[mem_wr.addr][mem_wr.lane*8 +: 8] <= mem_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= mem[{head_bank, w_r}];
      rd_desc_r <= head_desc;
      rd_word_r <= w_r;
      rd_last_r <= last;
      rd_mask_r <= mask;
    end
    if (rd_valid_r) begin
      out_desc_r <= rd_desc_r;
      out_word_r <= rd_word_r;
      out_data_r <= masked;
      out_last_r <= rd_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r         <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= issue;
      if (issue) begin
        w_r <= last ? '0 : w_r + 3'd1;
      end
      if (rd_valid_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_desc         = out_desc_r;
  assign out_word_index   = out_word_r;
  assign out_payload_word = out_data_r;
  assign out_last_word    = out_last_r;

endmodule

// ===== rtl/can_host_frame_rx_parser.sv =====
// Top level of the CAN FD host frame receive parser: front end, descriptor queue, back end.
// Input: one packet byte per cycle; bytes stall only while two accepted frames await drain.
// A frame's first word goes through the queue, the memory read and the output registers.
// A new payload memory read starts only once the previous read has left its register.
// Reset (rst_n low, synchronous) clears parser state, queue and output; channel_count is 1.
// Payload memory holds no reset value; a frame reads only bytes of its own packet.
`timescale 1ns / 1ps
module can_host_frame_rx_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  chfrp_byte_if.sink            in_ch,
  chfrp_result_if.source        out_ch,
  chfrp_cfg_if.sink             cfg_ch
);

  logic                    q_full;
  logic                    push;
  chfrp_pkg::frame_desc_t  push_desc;
  chfrp_pkg::mem_wr_t      mem_wr;
  logic                    pop;
  logic                    head_valid;
  chfrp_pkg::frame_desc_t  head_desc;
  logic                    head_bank;
  chfrp_pkg::frame_desc_t  out_desc;

  assign cfg_ch.ready = 1'b1;

  chfrp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_data_byte     (in_ch.data_byte),
    .in_end_of_packet (in_ch.end_of_packet),
    .in_ready         (in_ch.ready),
    .cfg_valid        (cfg_ch.valid),
    .cfg_reg_index    (cfg_ch.reg_index),
    .cfg_wdata        (cfg_ch.wdata),
    .q_full           (q_full),
    .push             (push),
    .push_desc        (push_desc),
    .mem_wr           (mem_wr)
  );

  chfrp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_desc  (push_desc),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .head_bank  (head_bank)
  );

  chfrp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .mem_wr           (mem_wr),
    .head_valid       (head_valid),
    .head_desc        (head_desc),
    .head_bank        (head_bank),
    .pop              (pop),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_desc         (out_desc),
    .out_word_index   (out_ch.word_index),
    .out_payload_word (out_ch.payload_word),
    .out_last_word    (out_ch.last_word)
  );

  assign out_ch.chan            = out_desc.chan;
  assign out_ch.frame_id        = out_desc.frame_id;
  assign out_ch.payload_length  = out_desc.payload_length;
  assign out_ch.is_fd           = out_desc.is_fd;
  assign out_ch.bit_rate_switch = out_desc.bit_rate_switch;
  assign out_ch.error_passive   = out_desc.error_passive;
  assign out_ch.timestamp_us    = out_desc.timestamp_us;

endmodule

// ===== rtl/chfrp_checker.sv =====
// Port-level checks on result words of the frame parser, bound to the top level.
`timescale 1ns / 1ps
module chfrp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [chfrp_pkg::LEN_W-1:0]  payload_length,
  input logic                         is_fd,
  input logic [2:0]                   word_index,
  input logic [63:0]                  payload_word,
  input logic                         last_word
);

  logic [chfrp_pkg::LEN_W-1:0] len_m1;
  assign len_m1 = payload_length - 7'd1;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(payload_word) && $stable(word_index))
    else $error("result word changed while stalled");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last_word |->
      word_index == ((payload_length == 7'd0) ? 3'd0 : len_m1[5:3]))
    else $error("last word index does not match payload length");

  a_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> payload_length <= 7'd64 && (is_fd || payload_length <= 7'd8))
    else $error("payload length out of range");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && payload_length == 7'd0 |-> payload_word == 64'd0 && last_word)
    else $error("zero-length frame carries data or extra words");

endmodule

bind can_host_frame_rx_parser chfrp_checker u_chfrp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .payload_length (out_ch.payload_length),
  .is_fd          (out_ch.is_fd),
  .word_index     (out_ch.word_index),
  .payload_word   (out_ch.payload_word),
  .last_word      (out_ch.last_word)
);
